### rtl/wum_pkg.sv
package wum_pkg;

  localparam int unsigned IndexW = 16;
  localparam int unsigned ValueW = 16;
  localparam int unsigned SizeW = 17;
  localparam int unsigned EdgeW = 18;
  localparam int unsigned DimW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [1:0] OpFlood = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StFlooded = 2'd0;
  localparam logic [1:0] StIgnored = 2'd1;
  localparam logic [1:0] StQuery = 2'd2;
  localparam logic [1:0] StCleared = 2'd3;

  localparam logic [CfgIdxW-1:0] RegWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLevel = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMerge = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [IndexW-1:0] pixel_index;
    logic signed [ValueW-1:0] pixel_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IndexW-1:0] root_index;
    logic [SizeW-1:0] root_size;
    logic is_raised;
    logic [3:0] edge_mask;
    logic [EdgeW-1:0] first_edge;
  } rsp_t;

endpackage

### rtl/wum_stream_if.sv
interface wum_stream_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/wum_store.sv
module wum_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16,
  parameter int unsigned DataW = 17
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/watershed_union_merge.sv
// channel | direction | payload
// req     | sink      | op, pixel_index, pixel_value
// rsp     | source    | status, root_index, root_size, is_raised, edge_mask, first_edge
// cfg     | write     | image_width, image_height, level_threshold, merge_limit
// One item at a time; not ready while an item is in work or its result awaits transfer.
// Results are registered. A query follows parent links to the root; a flood derives the
// pixel's coordinates by repeated subtraction, then follows the parent links of each raised
// neighbour to its root. Every access uses one read port a cycle.
// After reset and after a clear, a sweep over all MAX_PIXELS entries zeroes the link
// and size memories before the next item is taken.
module watershed_union_merge #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [wum_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wum_pkg::CfgDataW-1:0] cfg_data_i,
  wum_stream_if.sink req_i,
  wum_stream_if.source rsp_o
);
  import wum_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned CapN = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_CHK = 5'd2, S_CHKW = 5'd3,
                         S_DIV = 5'd4, S_INIT = 5'd5, S_NB = 5'd6, S_NBR = 5'd7,
                         S_FR = 5'd8, S_FRW = 5'd9, S_SZT = 5'd10, S_SZTW = 5'd11,
                         S_SZC = 5'd12, S_SZCW = 5'd13, S_LVT = 5'd14, S_LVTW = 5'd15,
                         S_LVC = 5'd16, S_LVCW = 5'd17, S_JOIN = 5'd18, S_OUT = 5'd19,
                         S_OUTW = 5'd20, S_DONE = 5'd21, S_QSZ = 5'd22, S_QSZW = 5'd23,
                         S_NBC = 5'd24;

  logic [4:0] st_q;
  logic [DimW-1:0] w_q, h_q;
  logic signed [ValueW-1:0] thr_q;
  logic [SizeW-1:0] ml_q;
  logic [EdgeW-1:0] ec_q;
  logic stop_q;
  logic [AW:0] clr_q;
  req_t r_q;
  rsp_t o_q;
  logic ov_q;
  logic [16:0] n_q;
  logic [8:0] ny_q, nx_q;
  logic [16:0] rem_q;
  logic [8:0] ix_q, iy_q;
  logic [1:0] d_q;
  logic joined_q;
  logic [AW-1:0] cur_q, top_q, nb_q;
  logic [SizeW-1:0] szt_q, szc_q;
  logic signed [ValueW-1:0] lvt_q;
  logic [3:0] mask_q;
  logic [4:0] ret_q;

  logic lk_we, sz_we, lv_we;
  logic [AW-1:0] lk_wa, sz_wa, lv_wa, lk_ra, sz_ra, lv_ra;
  logic [LW-1:0] lk_wd, lk_rd;
  logic [SizeW-1:0] sz_wd, sz_rd;
  logic [ValueW-1:0] lv_rd;

  wum_store #(.Depth(MAX_PIXELS), .AddrW(AW), .DataW(LW)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra),
    .rdata_o(lk_rd));
  wum_store #(.Depth(MAX_PIXELS), .AddrW(AW), .DataW(SizeW)) u_size (
    .clk_i, .we_i(sz_we), .waddr_i(sz_wa), .wdata_i(sz_wd), .raddr_i(sz_ra),
    .rdata_o(sz_rd));
  wum_store #(.Depth(MAX_PIXELS), .AddrW(AW), .DataW(ValueW)) u_level (
    .clk_i, .we_i(lv_we), .waddr_i(lv_wa), .wdata_i(r_q.pixel_value),
    .raddr_i(lv_ra), .rdata_o(lv_rd));

  logic [8:0] cw, ch;
  logic [17:0] prod;
  always_comb begin
    cw = (w_q == '0) ? 9'd1 : ((w_q > 9'd256) ? 9'd256 : w_q);
    ch = (h_q == '0) ? 9'd1 : ((h_q > 9'd256) ? 9'd256 : h_q);
    prod = 18'(cw) * 18'(ch);
  end

  logic [AW-1:0] idx_a;
  assign idx_a = AW'(r_q.pixel_index);

  // neighbour geometry
  logic signed [10:0] jx, jy;
  logic nb_ok;
  logic [17:0] nb_lin;
  always_comb begin
    jx = $signed({2'b0, ix_q});
    jy = $signed({2'b0, iy_q});
    unique case (d_q)
      2'd0: jy = jy + 11'sd1;
      2'd1: jx = jx + 11'sd1;
      2'd2: jy = jy - 11'sd1;
      default: jx = jx - 11'sd1;
    endcase
    nb_ok = (jx >= 0) && (jx < $signed({2'b0, nx_q})) && (jy >= 0) &&
            (jy < $signed({2'b0, ny_q}));
    nb_lin = 18'(jx[8:0]) * 18'(ny_q) + 18'(jy[8:0]);
    if (18'(nb_lin) >= 18'(n_q)) nb_ok = 1'b0;
  end

  logic [LW-1:0] pm1;
  logic fr_end;
  assign pm1 = lk_rd - LW'(1);
  assign fr_end = (lk_rd == '0) || (pm1 == LW'(top_q)) || (pm1 >= LW'(MAX_PIXELS));

  logic both_big, tgt;
  assign both_big = (szt_q >= ml_q) && (sz_rd >= ml_q);
  assign tgt = $signed(lvt_q) > $signed(lv_rd);

  always_comb begin
    lk_we = 1'b0; lk_wa = clr_q[AW-1:0]; lk_wd = '0; lk_ra = idx_a;
    sz_we = 1'b0; sz_wa = clr_q[AW-1:0]; sz_wd = '0; sz_ra = top_q;
    lv_we = 1'b0; lv_wa = idx_a; lv_ra = top_q;
    unique case (st_q)
      S_CLR: begin
        lk_we = 1'b1; sz_we = 1'b1;
      end
      S_INIT: begin
        lk_we = 1'b1; lk_wa = idx_a; lk_wd = LW'(idx_a) + LW'(1);
        sz_we = 1'b1; sz_wa = idx_a; sz_wd = SizeW'(1);
        lv_we = 1'b1;
      end
      S_NB: lk_ra = AW'(nb_lin);
      S_FR, S_FRW: lk_ra = top_q;
      S_SZC: sz_ra = cur_q;
      S_LVC, S_LVCW: lv_ra = cur_q;
      S_JOIN: begin
        if (!joined_q) begin
          lk_we = 1'b1; lk_wa = idx_a; lk_wd = LW'(top_q) + LW'(1);
          sz_we = 1'b1; sz_wa = top_q; sz_wd = szt_q + SizeW'(1);
        end else if (tgt) begin
          lk_we = 1'b1; lk_wa = cur_q; lk_wd = LW'(top_q) + LW'(1);
          sz_we = 1'b1; sz_wa = top_q; sz_wd = szt_q + szc_q;
        end else begin
          lk_we = 1'b1; lk_wa = top_q; lk_wd = LW'(cur_q) + LW'(1);
          sz_we = 1'b1; sz_wa = cur_q; sz_wd = szt_q + szc_q;
        end
      end
      S_OUT: sz_ra = cur_q;
      default: ;
    endcase
  end

  assign req_i.ready = (st_q == S_IDLE) && !ov_q;
  assign rsp_o.valid = ov_q;
  assign rsp_o.data = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; ov_q <= 1'b0; ec_q <= '0; stop_q <= 1'b0;
      w_q <= 9'd256; h_q <= 9'd256; thr_q <= 16'sh8000; ml_q <= 17'h10000;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWidth: w_q <= cfg_data_i[DimW-1:0];
          RegHeight: h_q <= cfg_data_i[DimW-1:0];
          RegLevel: thr_q <= cfg_data_i[ValueW-1:0];
          default: ml_q <= cfg_data_i;
        endcase
      end
      if (ov_q && rsp_o.ready) ov_q <= 1'b0;
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(MAX_PIXELS - 1)) begin
            st_q <= S_IDLE;
          end
        end
        S_IDLE: if (req_i.valid && !ov_q) begin
          r_q <= req_i.data;
          st_q <= S_CHK;
        end
        S_CHK: begin
          n_q <= (prod < 18'(CapN)) ? 17'(prod) : 17'(CapN);
          ny_q <= ch; nx_q <= cw;
          st_q <= S_CHKW;
        end
        S_CHKW: begin
          if (r_q.op == OpClear) begin
            o_q <= '{status: StCleared, default: '0};
            ec_q <= '0; stop_q <= 1'b0; clr_q <= '0;
            ov_q <= 1'b1; st_q <= S_CLR;
          end else if (r_q.op == OpQuery) begin
            o_q <= '{status: StQuery, default: '0};
            if (17'(r_q.pixel_index) < n_q && lk_rd != '0) begin
              top_q <= idx_a; ret_q <= S_QSZ; st_q <= S_FR;
            end else begin
              st_q <= S_DONE;
            end
          end else begin
            o_q <= '{status: StIgnored, default: '0};
            if (r_q.op == OpFlood && !stop_q && 17'(r_q.pixel_index) < n_q &&
                lk_rd == '0) begin
              if (r_q.pixel_value < thr_q) begin
                stop_q <= 1'b1; st_q <= S_DONE;
              end else begin
                rem_q <= 17'(r_q.pixel_index); ix_q <= '0; st_q <= S_DIV;
              end
            end else begin
              st_q <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (rem_q >= 17'(ny_q)) begin
            rem_q <= rem_q - 17'(ny_q); ix_q <= ix_q + 1'b1;
          end else begin
            iy_q <= rem_q[8:0]; st_q <= S_INIT;
          end
        end
        S_INIT: begin
          o_q.first_edge <= ec_q; cur_q <= idx_a; joined_q <= 1'b0;
          mask_q <= '0; d_q <= '0; st_q <= S_NB;
        end
        S_NB: begin
          nb_q <= AW'(nb_lin);
          st_q <= nb_ok ? S_NBR : S_NBC;
        end
        S_NBR: begin
          if (lk_rd == '0) begin
            st_q <= S_NBC;
          end else begin
            top_q <= nb_q; ret_q <= S_SZT; st_q <= S_FR;
          end
        end
        S_FR: st_q <= S_FRW;
        S_FRW: begin
          if (fr_end) st_q <= ret_q;
          else begin
            top_q <= pm1[AW-1:0]; st_q <= S_FR;
          end
        end
        S_SZT: st_q <= S_SZTW;
        S_SZTW: begin
          szt_q <= sz_rd;
          if (!joined_q) st_q <= S_JOIN;
          else if (top_q == cur_q) st_q <= S_NBC;
          else st_q <= S_SZC;
        end
        S_SZC: st_q <= S_SZCW;
        S_SZCW: begin
          szc_q <= sz_rd;
          st_q <= both_big ? S_NBC : S_LVT;
        end
        S_LVT: st_q <= S_LVTW;
        S_LVTW: begin
          lvt_q <= lv_rd; st_q <= S_LVC;
        end
        S_LVC: st_q <= S_LVCW;
        S_LVCW: st_q <= S_JOIN;
        S_JOIN: begin
          if (!joined_q || tgt) cur_q <= top_q;
          joined_q <= 1'b1;
          mask_q[d_q] <= 1'b1;
          ec_q <= ec_q + 1'b1;
          st_q <= S_NBC;
        end
        S_NBC: begin
          d_q <= d_q + 1'b1;
          st_q <= (d_q == 2'd3) ? S_OUT : S_NB;
        end
        S_OUT: st_q <= S_OUTW;
        S_OUTW: begin
          o_q.status <= StFlooded; o_q.root_index <= IndexW'(cur_q);
          o_q.root_size <= sz_rd; o_q.is_raised <= 1'b1; o_q.edge_mask <= mask_q;
          ov_q <= 1'b1; st_q <= S_IDLE;
        end
        S_QSZ: st_q <= S_QSZW;
        S_QSZW: begin
          o_q.root_index <= IndexW'(top_q); o_q.root_size <= sz_rd;
          o_q.is_raised <= 1'b1; ov_q <= 1'b1; st_q <= S_IDLE;
        end
        S_DONE: begin
          ov_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/wum_checker.sv
module wum_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input wum_pkg::rsp_t out_data_i
);
  import wum_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("rsp drop");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready after transfer");
  a_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == StIgnored || out_data_i.status == StCleared)
    |-> out_data_i.root_size == '0 && out_data_i.edge_mask == '0)
    else $error("bad fields");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("ready with pending rsp");
endmodule

bind watershed_union_merge wum_checker u_wum_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready), .out_data_i(rsp_o.data));
